// ----- hdl/cse_pkg.sv -----
// Shared types and constants for the CAN signal extractor.
// Used by every module under hdl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package cse_pkg;

    // Field widths fixed by the frame format and the register map.
    localparam int IdWidth     = 29;
    localparam int FrameIdW    = 32;
    localparam int DataWidth   = 64;
    localparam int RawWidth    = 33;
    localparam int PhysWidth   = 64;
    localparam int CfgWidth    = 32;
    localparam int CfgIdxWidth = 3;
    localparam int GatherBytes = 5;
    localparam int GatherWidth = GatherBytes * 8;

    // Register indexes of the configuration port.
    typedef enum logic [CfgIdxWidth-1:0] {
        REG_MATCH_ID  = 3'd0,
        REG_LSB_POS   = 3'd1,
        REG_FIELD_LEN = 3'd2,
        REG_MOTOROLA  = 3'd3,
        REG_SIGN_EXT  = 3'd4,
        REG_SCALE     = 3'd5,
        REG_OFFSET    = 3'd6
    } cse_reg_t;

    // Reset values of the registers, and the longest field length.
    localparam logic [5:0]         FieldLenReset = 6'd8;
    localparam logic signed [31:0] ScaleReset    = 32'sd65536;
    localparam logic [5:0]         MaxLength     = 6'd32;

    // Signal description as seen by the datapath.
    typedef struct packed {
        logic [IdWidth-1:0]    match_id;
        logic [5:0]            lsb_pos;
        logic [5:0]            field_len;
        logic                  motorola;
        logic                  sign_ext;
        logic signed [31:0]    scale;
        logic signed [31:0]    offset;
    } cse_cfg_t;

endpackage

`default_nettype wire

// ----- hdl/cse_extract.sv -----
// Identifier match, byte gather and field cut: two pipeline stages.
// Depends on cse_pkg for the configuration struct and widths.
`timescale 1ns / 1ps
`default_nettype none

module cse_extract (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cse_pkg::cse_cfg_t              cfg,
    input  wire logic                           up_valid,
    output logic                                up_stall,
    input  wire logic [cse_pkg::FrameIdW-1:0]   frame_id,
    input  wire logic [cse_pkg::DataWidth-1:0]  frame_data,
    output logic                                down_valid,
    input  wire logic                           down_stall,
    output logic signed [cse_pkg::RawWidth-1:0] raw
);
    import cse_pkg::*;

    logic                   a_valid_reg;
    logic                   a_valid_next;
    logic [GatherWidth-1:0] a_acc_reg;
    logic [GatherWidth-1:0] a_acc_next;
    logic                   b_valid_reg;
    logic signed [RawWidth-1:0] b_raw_reg;
    logic signed [RawWidth-1:0] b_raw_next;
    logic                   a_en;
    logic                   b_en;
    logic                   b_hold;
    logic [2:0]             first_byte;
    logic [5:0]             len;
    logic [RawWidth-1:0]    mask;
    logic [RawWidth-1:0]    top_bit;
    logic [GatherWidth-1:0] shifted;
    logic [31:0]            field;
    logic                   neg;

    // Handshake: stage B empties when downstream takes the word.
    assign b_en     = !b_valid_reg || !down_stall;
    assign b_hold   = b_valid_reg && down_stall;
    assign a_en     = !a_valid_reg || !b_hold;
    assign up_stall = a_valid_reg && b_hold;

    // Stage A: frames for other identifiers are dropped here.
    assign a_valid_next = up_valid && (frame_id[IdWidth-1:0] == cfg.match_id);
    assign first_byte   = cfg.lsb_pos[5:3];

    // Gather five bytes walking up (Intel) or down (Motorola) from the first.
    for (genvar k = 0; k < GatherBytes; k++) begin : g_gather
        logic [4:0] idx;
        assign idx = cfg.motorola ? ({2'b00, first_byte} - 5'(k))
                                  : ({2'b00, first_byte} + 5'(k));
        assign a_acc_next[k*8 +: 8] = (idx[4:3] == 2'b00)
                                    ? frame_data[{idx[2:0], 3'b000} +: 8] : 8'h00;
    end

    // Stage B: shift, mask and sign-extend the field.
    always_comb
    begin
        len     = (cfg.field_len > MaxLength) ? MaxLength : cfg.field_len;
        mask    = (RawWidth'(1) << len) - RawWidth'(1);
        top_bit = mask ^ (mask >> 1);
        shifted = a_acc_reg >> cfg.lsb_pos[2:0];
        field   = shifted[31:0] & mask[31:0];
        neg     = cfg.sign_ext && (|(field & top_bit[31:0]));
        b_raw_next = neg ? $signed({1'b0, field} | ~mask) : $signed({1'b0, field});
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= a_valid_next;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_acc_reg <= a_acc_next;
        end
        if (b_en)
        begin
            b_raw_reg <= b_raw_next;
        end
    end

    assign down_valid = b_valid_reg;
    assign raw        = b_raw_reg;

endmodule

`default_nettype wire

// ----- hdl/cse_scale.sv -----
// Scaling: one multiply stage and one saturating add stage.
// Depends on cse_pkg for the configuration struct and widths.
`timescale 1ns / 1ps
`default_nettype none

module cse_scale (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire cse_pkg::cse_cfg_t               cfg,
    input  wire logic                            up_valid,
    output logic                                 up_stall,
    input  wire logic signed [cse_pkg::RawWidth-1:0] raw,
    output logic                                 down_valid,
    input  wire logic                            down_stall,
    output logic signed [cse_pkg::RawWidth-1:0]  raw_out,
    output logic signed [cse_pkg::PhysWidth-1:0] phys_out
);
    import cse_pkg::*;

    logic                        c_valid_reg;
    logic signed [RawWidth-1:0]  c_raw_reg;
    logic signed [PhysWidth-1:0] c_prod_reg;
    logic signed [PhysWidth-1:0] c_prod_next;
    logic signed [PhysWidth:0]   prod_full;
    logic                        d_valid_reg;
    logic signed [RawWidth-1:0]  d_raw_reg;
    logic signed [PhysWidth-1:0] d_phys_reg;
    logic signed [PhysWidth-1:0] d_phys_next;
    logic signed [PhysWidth:0]   sum;
    logic                        c_en;
    logic                        d_en;
    logic                        d_hold;

    // Handshake: stage D is the output register.
    assign d_en     = !d_valid_reg || !down_stall;
    assign d_hold   = d_valid_reg && down_stall;
    assign c_en     = !c_valid_reg || !d_hold;
    assign up_stall = c_valid_reg && d_hold;

    // Stage C: the product always fits in 64 bits.
    assign prod_full   = raw * cfg.scale;
    assign c_prod_next = prod_full[PhysWidth-1:0];

    // Stage D: add the offset and clamp on overflow.
    always_comb
    begin
        sum = {c_prod_reg[PhysWidth-1], c_prod_reg}
            + {{(PhysWidth + 1 - 32){cfg.offset[31]}}, cfg.offset};
        if (sum[PhysWidth] != sum[PhysWidth-1])
        begin
            d_phys_next = sum[PhysWidth] ? {1'b1, {(PhysWidth-1){1'b0}}}
                                         : {1'b0, {(PhysWidth-1){1'b1}}};
        end
        else
        begin
            d_phys_next = sum[PhysWidth-1:0];
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_en)
            begin
                c_valid_reg <= up_valid;
            end
            if (d_en)
            begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (c_en)
        begin
            c_raw_reg  <= raw;
            c_prod_reg <= c_prod_next;
        end
        if (d_en)
        begin
            d_raw_reg  <= c_raw_reg;
            d_phys_reg <= d_phys_next;
        end
    end

    assign down_valid = d_valid_reg;
    assign raw_out    = d_raw_reg;
    assign phys_out   = d_phys_reg;

endmodule

`default_nettype wire

// ----- hdl/can_signal_extract.sv -----
// Top level of the CAN signal extractor: register file and pipeline.
// Depends on cse_pkg, cse_extract and cse_scale.
//
// Usage:
// A received frame enters on the input channel (in_valid, in_stall,
// frame_id, frame_data). Frames whose low 29 identifier bits differ from
// match_id are taken and dropped. A matching frame gives one word on the
// output channel: field_raw and field_scaled = raw * scale + offset in
// Q48.16, clamped to the 64-bit range.
// The pipeline has four register stages (gather, field cut, multiply,
// saturating add), passed in that order; out_valid is driven from the last.
// A frame can be taken in every cycle that in_stall is low; throughput is
// one frame per cycle. When the receiver stalls, the stages fill up behind
// the output register and in_stall rises only once all four hold a word;
// nothing is lost. Reset clears all valid bits and loads the register
// defaults (length 8, scale 1.0, Intel order, unsigned). Registers are
// written through cfg_write, cfg_index and cfg_data; the user must write
// them only while the pipeline is empty, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module can_signal_extract (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [cse_pkg::CfgIdxWidth-1:0]   cfg_index,
    input  wire logic [cse_pkg::CfgWidth-1:0]      cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [cse_pkg::FrameIdW-1:0]      frame_id,
    input  wire logic [cse_pkg::DataWidth-1:0]     frame_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [cse_pkg::RawWidth-1:0]    field_raw,
    output logic signed [cse_pkg::PhysWidth-1:0]   field_scaled
);
    import cse_pkg::*;

    cse_cfg_t                   cfg_reg;
    logic                       mid_valid;
    logic                       mid_stall;
    logic signed [RawWidth-1:0] mid_raw;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_id  <= '0;
            cfg_reg.lsb_pos   <= '0;
            cfg_reg.field_len <= FieldLenReset;
            cfg_reg.motorola  <= 1'b0;
            cfg_reg.sign_ext  <= 1'b0;
            cfg_reg.scale     <= ScaleReset;
            cfg_reg.offset    <= '0;
        end
        else if (cfg_write)
        begin
            case (cse_reg_t'(cfg_index))
                REG_MATCH_ID:  cfg_reg.match_id  <= cfg_data[IdWidth-1:0];
                REG_LSB_POS:   cfg_reg.lsb_pos   <= cfg_data[5:0];
                REG_FIELD_LEN: cfg_reg.field_len <= cfg_data[5:0];
                REG_MOTOROLA:  cfg_reg.motorola  <= cfg_data[0];
                REG_SIGN_EXT:  cfg_reg.sign_ext  <= cfg_data[0];
                REG_SCALE:     cfg_reg.scale     <= $signed(cfg_data);
                REG_OFFSET:    cfg_reg.offset    <= $signed(cfg_data);
                default:       ;
            endcase
        end
    end

    // Field extraction stages.
    cse_extract u_extract (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .up_valid   (in_valid),
        .up_stall   (in_stall),
        .frame_id   (frame_id),
        .frame_data (frame_data),
        .down_valid (mid_valid),
        .down_stall (mid_stall),
        .raw        (mid_raw)
    );

    // Scaling stages.
    cse_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .up_valid   (mid_valid),
        .up_stall   (mid_stall),
        .raw        (mid_raw),
        .down_valid (out_valid),
        .down_stall (out_stall),
        .raw_out    (field_raw),
        .phys_out   (field_scaled)
    );

    // The input only stalls when the whole pipeline is held by the receiver.
    a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && mid_valid && mid_stall))
        else $error("input stalled while the pipeline has room");

    // An unsigned field never sets the raw sign bit.
    a_unsigned_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !cfg_reg.sign_ext) |-> (field_raw[RawWidth-1] == 1'b0))
        else $error("sign bit set on an unsigned field");

    // A zero-length field gives zero and passes the offset through.
    a_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && cfg_reg.field_len == 6'd0) |->
        (field_raw == '0 && field_scaled == PhysWidth'(cfg_reg.offset)))
        else $error("zero-length field gave a nonzero result");

    // A word held by the receiver keeps its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(field_scaled)))
        else $error("held output word changed");

endmodule

`default_nettype wire

// ----- dv/can_signal_extract_tb.sv -----
// Self-checking testbench for can_signal_extract: directed frames, then random frames.
// Expected words come from a decoder model in this file, or a table for typed frames.
// Depends on cse_pkg and the can_signal_extract RTL only.
`timescale 1ns / 1ps

module can_signal_extract_tb;

    import cse_pkg::*;

    localparam int unsigned CycleLimit     = 200_000;
    localparam int unsigned DrainCycles    = 10;
    localparam int unsigned HoldCycles     = 200;
    localparam int unsigned ItemsPerBlock  = 65;
    localparam int unsigned SendIdlePct [4] = '{0, 47, 0, 11};
    localparam int unsigned RecvStallPct[4] = '{0, 0, 47, 11};

    // One expected output word.
    typedef struct packed {
        logic [RawWidth-1:0]  raw;
        logic [PhysWidth-1:0] phys;
    } signal_word_t;

    // One directed frame; raw and phys count only when typed is set.
    typedef struct packed {
        logic [2:0]           setting;
        logic [FrameIdW-1:0]  fid;
        logic [DataWidth-1:0] data;
        logic                 typed;
        logic                 hit;
        logic [RawWidth-1:0]  raw;
        logic [PhysWidth-1:0] phys;
    } frame_case_t;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      cfg_write  = 1'b0;
    logic [CfgIdxWidth-1:0]    cfg_index  = '0;
    logic [CfgWidth-1:0]       cfg_data   = '0;
    logic                      in_valid   = 1'b0;
    logic                      in_stall;
    logic [FrameIdW-1:0]       frame_id   = '0;
    logic [DataWidth-1:0]      frame_data = '0;
    logic                      out_valid;
    logic                      out_stall  = 1'b0;
    logic signed [RawWidth-1:0]  field_raw;
    logic signed [PhysWidth-1:0] field_scaled;

    // Register settings used by the directed frames; entry 0 is the reset state.
    cse_cfg_t dir_cfg [8] = '{
        '{29'h0,         6'd0,  FieldLenReset, 1'b0, 1'b0, ScaleReset,     32'sh0},
        '{29'h1FFF_FFFF, 6'd63, 6'd32, 1'b0, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF},
        '{29'h123,       6'd0,  6'd32, 1'b0, 1'b0, 32'sh8000_0000, 32'sh8000_0000},
        '{29'h123,       6'd12, 6'd16, 1'b1, 1'b1, 32'sh0001_0000, 32'sh0},
        '{29'h7FF,       6'd5,  6'd0,  1'b0, 1'b1, 32'sh0001_2345, 32'shFFFF_0000},
        '{29'h1555_5555, 6'd8,  6'd63, 1'b0, 1'b1, 32'shFFFF_0000, 32'sh0001_0000},
        '{29'h0AAA_AAAA, 6'd0,  6'd1,  1'b0, 1'b1, 32'sh0001_0000, 32'sh0},
        '{29'h1000_0000, 6'd63, 6'd32, 1'b1, 1'b0, 32'sh0000_0100, 32'shFFFF_FFFF}
    };

    // Directed frames: reset defaults, identifier flags, extremes, zero and
    // overlong lengths, fields running off either end of the frame.
    frame_case_t dir_cases [19] = '{
        '{0, 32'h0000_0000, 64'h0000_0000_0000_00A5, 1, 1, 33'h0A5, 64'h00A5_0000},
        '{0, 32'hE000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 33'h0FF, 64'h00FF_0000},
        '{0, 32'h0000_0001, 64'h0000_0000_0000_0000, 1, 0, 33'h0, 64'h0},
        '{1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 33'h0, 64'h0},
        '{1, 32'h1FFF_FFFF, 64'h0000_0000_0000_0000, 1, 1, 33'h0, 64'h7FFF_FFFF},
        '{1, 32'h0FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 33'h0, 64'h0},
        '{2, 32'h0000_0123, 64'h0000_0000_FFFF_FFFF, 1, 1, 33'h0_FFFF_FFFF,
          64'h8000_0000_0000_0000},
        '{2, 32'h2000_0123, 64'hFFFF_FFFF_0000_0000, 1, 1, 33'h0, 64'hFFFF_FFFF_8000_0000},
        '{3, 32'h0000_0123, 64'h0123_4567_89AB_CDEF, 0, 0, 33'h0, 64'h0},
        '{3, 32'h0000_0123, 64'h0000_0000_0000_8F7F, 0, 0, 33'h0, 64'h0},
        '{4, 32'h0000_07FF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 33'h0, 64'hFFFF_FFFF_FFFF_0000},
        '{5, 32'h1555_5555, 64'h0000_0080_0000_0000, 0, 0, 33'h0, 64'h0},
        '{5, 32'h1555_5555, 64'h0000_007F_FFFF_FF00, 0, 0, 33'h0, 64'h0},
        '{6, 32'h0AAA_AAAA, 64'h0000_0000_0000_0001, 1, 1, 33'h1_FFFF_FFFF,
          64'hFFFF_FFFF_FFFF_0000},
        '{6, 32'h0AAA_AAAA, 64'hFFFF_FFFF_FFFF_FFFE, 1, 1, 33'h0, 64'h0},
        '{7, 32'h1000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 33'h0, 64'h0},
        '{7, 32'h1000_0000, 64'h8000_0001_0000_0000, 0, 0, 33'h0, 64'h0},
        '{7, 32'hF000_0000, 64'h7FFF_FFFE_FFFF_FFFF, 0, 0, 33'h0, 64'h0},
        '{0, 32'h0000_0000, 64'h0000_0000_0000_0000, 0, 0, 33'h0, 64'h0}
    };

    // Register copy for the decoder model, starting from reset values.
    cse_cfg_t sig_cfg = '{29'h0, 6'd0, FieldLenReset, 1'b0, 1'b0, ScaleReset, 32'sh0};

    signal_word_t pending_words[$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count    = 0;
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  hold_asks      = 0;
    int unsigned  hold_seen      = 0;
    int unsigned  hold_left      = 0;

    can_signal_extract i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .frame_id     (frame_id),
        .frame_data   (frame_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .field_raw    (field_raw),
        .field_scaled (field_scaled)
    );

    // Clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("[can_signal_extract] ERROR");
            $finish;
        end
    end

    // Decode one frame with the current registers. Returns 0 when the
    // identifier does not match and no word is produced.
    function automatic bit decode_signal(input logic [FrameIdW-1:0] fid,
                                         input logic [DataWidth-1:0] data,
                                         output signal_word_t word);
        int                len;
        int                shift;
        int                first;
        int                nbytes;
        int                k;
        int                idx;
        logic [63:0]       gathered;
        logic [63:0]       field;
        longint            raw_l;
        longint            prod;
        logic signed [64:0] total;
        word = '0;
        if (fid[IdWidth-1:0] != sig_cfg.match_id)
            return 1'b0;
        len    = (sig_cfg.field_len > MaxLength) ? 32 : int'(sig_cfg.field_len);
        shift  = int'(sig_cfg.lsb_pos[2:0]);
        first  = int'(sig_cfg.lsb_pos[5:3]);
        nbytes = (shift + len + 7) / 8;

        // Collect the bytes the field touches; bytes off the frame stay zero.
        gathered = '0;
        for (k = 0; k < nbytes; k++)
        begin
            idx = sig_cfg.motorola ? first - k : first + k;
            if (idx >= 0 && idx <= 7)
                gathered |= ((data >> (8 * idx)) & 64'hFF) << (8 * k);
        end
        field = (len == 0) ? 64'd0 : (gathered >> shift) & ((64'd1 << len) - 64'd1);

        raw_l = longint'(field);
        if (sig_cfg.sign_ext && len > 0)
        begin
            if (field[len - 1])
                raw_l = raw_l - (longint'(1) << len);
        end

        // Product always fits in 64 bits; only the offset add can overflow.
        prod  = raw_l * longint'($signed(sig_cfg.scale));
        total = prod;
        total = total + $signed(sig_cfg.offset);
        if (total[64] != total[63])
            word.phys = total[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            word.phys = total[63:0];
        word.raw = raw_l[RawWidth-1:0];
        return 1'b1;
    endfunction

    // Random Q16.16 value biased toward extremes and small magnitudes.
    function automatic logic [31:0] random_q16();
        logic [31:0] r;
        case ($urandom_range(5))
            0: r = 32'h7FFF_FFFF;
            1: r = 32'h8000_0000;
            2, 3:
            begin
                r = $urandom_range(32'h0004_0000);
                if ($urandom_range(1) != 0)
                    r = -r;
            end
            default: r = $urandom;
        endcase
        return r;
    endfunction

    function automatic cse_cfg_t random_setting();
        cse_cfg_t    c;
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7))
            0: c.match_id = '0;
            1: c.match_id = '1;
            default: c.match_id = r[IdWidth-1:0];
        endcase
        c.lsb_pos = 6'($urandom_range(63));
        case ($urandom_range(15))
            0: c.field_len = 6'd0;
            1: c.field_len = 6'($urandom_range(63, 33));
            default: c.field_len = 6'($urandom_range(32, 1));
        endcase
        c.motorola = 1'($urandom_range(1));
        c.sign_ext = 1'($urandom_range(1));
        c.scale    = random_q16();
        c.offset   = random_q16();
        return c;
    endfunction

    // Single register write; the model copy follows the register map masks.
    task automatic write_reg(input cse_reg_t idx, input logic [CfgWidth-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_MATCH_ID:  sig_cfg.match_id  = value[IdWidth-1:0];
            REG_LSB_POS:   sig_cfg.lsb_pos   = value[5:0];
            REG_FIELD_LEN: sig_cfg.field_len = value[5:0];
            REG_MOTOROLA:  sig_cfg.motorola  = value[0];
            REG_SIGN_EXT:  sig_cfg.sign_ext  = value[0];
            REG_SCALE:     sig_cfg.scale     = value;
            REG_OFFSET:    sig_cfg.offset    = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Write every register; unused upper bits carry junk that must be ignored.
    task automatic apply_setting(input cse_cfg_t c);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_MATCH_ID,  {junk[31:29], c.match_id});
        write_reg(REG_LSB_POS,   {junk[31:6], c.lsb_pos});
        write_reg(REG_FIELD_LEN, {junk[25:0], c.field_len});
        write_reg(REG_MOTOROLA,  {junk[30:0], c.motorola});
        write_reg(REG_SIGN_EXT,  {junk[31:1], c.sign_ext});
        write_reg(REG_SCALE,     c.scale);
        write_reg(REG_OFFSET,    c.offset);
        cfg_write <= 1'b0;
    endtask

    // Stop sending, wait for every expected word, then let dropped frames
    // leave the pipeline before the registers may change.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Offer one frame, with optional idle cycles ahead of it. Acceptance is
    // sampled at the falling edge, where all handshake signals are stable.
    task automatic send_frame(input logic [FrameIdW-1:0] fid,
                              input logic [DataWidth-1:0] data,
                              input bit typed, input bit hit,
                              input logic [RawWidth-1:0] raw_t,
                              input logic [PhysWidth-1:0] phys_t);
        bit           taken;
        bit           matched;
        signal_word_t word;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid   <= 1'b1;
        frame_id   <= fid;
        frame_data <= data;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        matched = decode_signal(fid, data, word);
        if (typed)
        begin
            matched   = hit;
            word.raw  = raw_t;
            word.phys = phys_t;
        end
        if (matched)
            pending_words.push_back(word);
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_seen <= hold_asks;
            hold_left <= HoldCycles;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Compare each accepted output word with the oldest expectation.
    always @(negedge clk)
    begin : check_words
        signal_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected word: field_raw %h, field_scaled %h",
                       field_raw, field_scaled);
                mismatch_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (field_raw !== want.raw)
                begin
                    $error("field_raw: expected %h, actual %h", want.raw, field_raw);
                    mismatch_count++;
                end
                if (field_scaled !== want.phys)
                begin
                    $error("field_scaled: expected %h, actual %h",
                           want.phys, field_scaled);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus.
    initial
    begin
        int unsigned         n;
        int unsigned         ph;
        int unsigned         blk;
        int unsigned         cur_setting;
        int unsigned         pick;
        logic [FrameIdW-1:0]  fid;
        logic [DataWidth-1:0] data;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part; registers start at their reset values.
        cur_setting = 0;
        for (n = 0; n < $size(dir_cases); n++)
        begin
            if (dir_cases[n].setting != cur_setting)
            begin
                settle();
                cur_setting = dir_cases[n].setting;
                apply_setting(dir_cfg[cur_setting]);
            end
            send_frame(dir_cases[n].fid, dir_cases[n].data, dir_cases[n].typed,
                       dir_cases[n].hit, dir_cases[n].raw, dir_cases[n].phys);
        end

        // Random part: four idling phases, each with several register settings.
        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = SendIdlePct[ph];
            recv_stall_pct = RecvStallPct[ph];
            for (blk = 0; blk < 4; blk++)
            begin
                settle();
                apply_setting(random_setting());
                // Long receiver hold-off so the pipeline fills and stalls input.
                if (blk == 1 && ph[0] == 1'b0)
                    hold_asks <= hold_asks + 1;
                for (n = 0; n < ItemsPerBlock; n++)
                begin
                    pick = $urandom_range(99);
                    fid  = $urandom;
                    if (pick < 75)
                        fid[IdWidth-1:0] = sig_cfg.match_id;
                    else if (pick < 88)
                        fid[IdWidth-1:0] = sig_cfg.match_id ^ (29'd1 << $urandom_range(28));
                    case ($urandom_range(9))
                        0: data = '1;
                        1: data = '0;
                        default: data = {$urandom, $urandom};
                    endcase
                    send_frame(fid, data, 1'b0, 1'b0, '0, '0);
                end
            end
        end

        // Drain and report.
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (mismatch_count == 0)
            $display("[can_signal_extract] OK");
        else
            $display("[can_signal_extract] ERROR");
        $finish;
    end

endmodule
